// ===== rtl/core/differential_drive_odometry_defines.svh =====
// Assertion macros for the differential drive odometry block.
// Needs nothing else; included by files that carry assertions.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_DEFINES_SVH

// same-cycle implication
`define DDO_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ddo check failed");

// next-cycle implication
`define DDO_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ddo check failed");

`endif

// ===== rtl/core/ddo_pkg.sv =====
// Package for the differential drive odometry block: widths, fixed-point
// constants, CORDIC arctangent table and the sequencer microcode ROM. No deps.
`default_nettype none

package ddo_pkg;

   // stream widths
   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 88;

   // CORDIC iteration count, clamped to the table length
   localparam int CORDIC_ITERS = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int ITER_COUNT   = (CORDIC_ITERS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_ITERS;
   localparam int ITER_W       = $clog2(ATAN_ENTRIES);
   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ITER_COUNT - 1);

   // internal widths
   localparam int PWR_W  = 16;
   localparam int SUM_W  = 17;
   localparam int HDG_W  = 19;
   localparam int ANG_W  = 21;
   localparam int XY_W   = 32;
   localparam int POS_W  = 32;
   localparam int PROD_W = SUM_W + XY_W;
   localparam int ATAN_W = 17;

   // angles in Q.16
   localparam logic signed [ANG_W-1:0] PI_A      = 21'sd205887;
   localparam logic signed [ANG_W-1:0] TWO_PI_A  = 21'sd411775;
   localparam logic signed [ANG_W-1:0] HALF_PI_A = 21'sd102944;
   localparam logic signed [HDG_W-1:0] PI_H      = 19'sd205887;

   // CORDIC start vector, gain compensated, Q.30
   localparam logic signed [XY_W-1:0] CORDIC_K = 32'sd652032874;

   function automatic logic [ATAN_W-1:0] atan_q16(input logic [ITER_W-1:0] idx);
      logic [ATAN_W-1:0] v;
      case (idx)
         5'd0:    v = 17'd51472;
         5'd1:    v = 17'd30386;
         5'd2:    v = 17'd16055;
         5'd3:    v = 17'd8150;
         5'd4:    v = 17'd4091;
         5'd5:    v = 17'd2047;
         5'd6:    v = 17'd1024;
         5'd7:    v = 17'd512;
         5'd8:    v = 17'd256;
         5'd9:    v = 17'd128;
         5'd10:   v = 17'd64;
         5'd11:   v = 17'd32;
         5'd12:   v = 17'd16;
         5'd13:   v = 17'd8;
         5'd14:   v = 17'd4;
         5'd15:   v = 17'd2;
         5'd16:   v = 17'd1;
         default: v = '0;
      endcase
      return v;
   endfunction

   // pose plus scaled displacement, saturated to 32 bits
   function automatic logic signed [POS_W-1:0] sat_add(input logic signed [POS_W-1:0] pos,
                                                        input logic signed [PROD_W-1:0] prod);
      logic signed [POS_W+1:0] s;
      logic signed [POS_W-1:0] r;
      s = (POS_W+2)'(pos) + (POS_W+2)'($signed(prod[PROD_W-1:29]));
      if (s[POS_W+1:POS_W-1] == 3'b000 || s[POS_W+1:POS_W-1] == 3'b111) begin
         r = s[POS_W-1:0];
      end else if (s[POS_W+1]) begin
         r = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(POS_W-1){1'b1}}};
      end
      return r;
   endfunction

   // microcode
   localparam int PC_W = 3;

   typedef enum logic [2:0] {
      OP_WAIT  = 3'd0,
      OP_WHEEL = 3'd1,
      OP_ITER  = 3'd2,
      OP_MULX  = 3'd3,
      OP_ADDX  = 3'd4,
      OP_MULY  = 3'd5,
      OP_ADDY  = 3'd6,
      OP_DONE  = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      C_NEXT      = 2'd0,
      C_REQ_IDLE  = 2'd1,
      C_ITER_MORE = 2'd2,
      C_RSP_BUSY  = 2'd3
   } cond_type;

   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } ctrl_type;

   localparam logic [PC_W-1:0] STEP_WAIT = 3'd0;
   localparam logic [PC_W-1:0] STEP_ITER = 3'd2;
   localparam logic [PC_W-1:0] STEP_DONE = 3'd7;

   // last step falls through to step 0 by pc wrap
   function automatic ctrl_type ucode_rom(input logic [PC_W-1:0] pc);
      ctrl_type w;
      case (pc)
         3'd0:    w = '{op: OP_WAIT,  cond: C_REQ_IDLE,  target: STEP_WAIT};
         3'd1:    w = '{op: OP_WHEEL, cond: C_NEXT,      target: STEP_WAIT};
         3'd2:    w = '{op: OP_ITER,  cond: C_ITER_MORE, target: STEP_ITER};
         3'd3:    w = '{op: OP_MULX,  cond: C_NEXT,      target: STEP_WAIT};
         3'd4:    w = '{op: OP_ADDX,  cond: C_NEXT,      target: STEP_WAIT};
         3'd5:    w = '{op: OP_MULY,  cond: C_NEXT,      target: STEP_WAIT};
         3'd6:    w = '{op: OP_ADDY,  cond: C_NEXT,      target: STEP_WAIT};
         3'd7:    w = '{op: OP_DONE,  cond: C_RSP_BUSY,  target: STEP_DONE};
         default: w = '{op: OP_WAIT,  cond: C_REQ_IDLE,  target: STEP_WAIT};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/differential_drive_odometry.sv =====
// Top level of the differential drive odometry block: microcoded sequencer
// and datapath. Depends on ddo_pkg and differential_drive_odometry_defines.svh.
`default_nettype none
`include "differential_drive_odometry_defines.svh"

// Dead-reckoning odometry for a two-wheel robot. Each request word carries
// the left and right motor powers (Q2.14) and a restart flag; each response
// word carries the new x and y position (Q16.16, saturating) and the new
// heading (Q3.16 radians, wrapped to [-pi, pi]). An item steps the sequencer
// through one accept step, one wheel/heading step, ITER_COUNT CORDIC
// iterations (16 by default) at one per cycle on the single shift-add unit,
// two multiply steps on the one shared 17x32 multiplier, two accumulate
// steps and one result step. The response register loads in the result
// step once it is free.
// The response sits in an output register, so the next request is taken
// while the previous response waits; a response that is still held when the
// next one is ready stalls the sequencer at its last step.
module differential_drive_odometry (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request stream
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   // [15:0] left_power, [31:16] right_power
   input  wire logic [ddo_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [0] restart
   input  wire logic [ddo_pkg::REQ_USER_W-1:0]  req_tuser,
   // response stream
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [31:0] x_pos, [63:32] y_pos, [82:64] heading_out, [87:83] zero
   output      logic [ddo_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import ddo_pkg::*;

   // sequencer
   logic [PC_W-1:0] pc_ff, pc_in;
   ctrl_type        ctrl;
   logic            req_accept;
   logic            rsp_free;

   // persistent state
   logic signed [PWR_W-1:0] prev_l_ff, prev_l_in;
   logic signed [PWR_W-1:0] prev_r_ff, prev_r_in;
   logic signed [POS_W-1:0] pose_x_ff, pose_x_in;
   logic signed [POS_W-1:0] pose_y_ff, pose_y_in;
   logic signed [HDG_W-1:0] heading_ff, heading_in;

   // per-item work registers
   logic signed [PWR_W-1:0]  lp_ff, lp_in;
   logic signed [PWR_W-1:0]  rp_ff, rp_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [XY_W-1:0]   x_ff, x_in;
   logic signed [XY_W-1:0]   y_ff, y_in;
   logic signed [ANG_W-1:0]  z_ff, z_in;
   logic                     neg_ff, neg_in;
   logic [ITER_W-1:0]        iter_ff, iter_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   // response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [POS_W-1:0] rsp_x_ff, rsp_x_in;
   logic signed [POS_W-1:0] rsp_y_ff, rsp_y_in;
   logic signed [HDG_W-1:0] rsp_heading_ff, rsp_heading_in;

   // datapath terms
   logic signed [PWR_W+1:0] wheel_l_sum, wheel_r_sum;
   logic signed [PWR_W-1:0] out_l, out_r;
   logic signed [SUM_W-1:0] diff_lr;
   logic signed [ANG_W-1:0] h_raw, h_wrap;
   logic signed [ANG_W-1:0] h_old;
   logic signed [XY_W-1:0]  xs, ys;
   logic [ATAN_W-1:0]       atan_val;
   logic signed [XY_W-1:0]  trig, mul_op;

   assign ctrl       = ucode_rom(pc_ff);
   assign req_tready = (ctrl.op == OP_WAIT);
   assign req_accept = req_tvalid & req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // wheel output: floor((p + 2*prev) / 4)
   assign wheel_l_sum = (PWR_W+2)'(lp_ff) + (PWR_W+2)'($signed({prev_l_ff, 1'b0}));
   assign wheel_r_sum = (PWR_W+2)'(rp_ff) + (PWR_W+2)'($signed({prev_r_ff, 1'b0}));
   assign out_l       = wheel_l_sum[PWR_W+1:2];
   assign out_r       = wheel_r_sum[PWR_W+1:2];

   // heading gains 4*(right - left), wrapped once by 2*pi
   assign diff_lr = SUM_W'(out_r) - SUM_W'(out_l);
   assign h_old   = ANG_W'(heading_ff);
   assign h_raw   = h_old + ANG_W'($signed({diff_lr, 2'b00}));
   always_comb begin
      if (h_raw > PI_A) begin
         h_wrap = h_raw - TWO_PI_A;
      end else if (h_raw < -PI_A) begin
         h_wrap = h_raw + TWO_PI_A;
      end else begin
         h_wrap = h_raw;
      end
   end

   // CORDIC shift-add unit
   assign xs       = x_ff >>> iter_ff;
   assign ys       = y_ff >>> iter_ff;
   assign atan_val = atan_q16(iter_ff);

   // shared multiplier operand: cos for x, sin for y, sign fixed by pre-rotation
   assign trig   = (ctrl.op == OP_MULY) ? y_ff : x_ff;
   assign mul_op = neg_ff ? -trig : trig;

   always_comb begin
      pc_in          = pc_ff + PC_W'(1);
      prev_l_in      = prev_l_ff;
      prev_r_in      = prev_r_ff;
      pose_x_in      = pose_x_ff;
      pose_y_in      = pose_y_ff;
      heading_in     = heading_ff;
      lp_in          = lp_ff;
      rp_in          = rp_ff;
      sum_in         = sum_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      z_in           = z_ff;
      neg_in         = neg_ff;
      iter_in        = iter_ff;
      prod_in        = prod_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_heading_in = rsp_heading_ff;

      case (ctrl.op)
         OP_WAIT: begin
            if (req_accept) begin
               lp_in = req_tdata[15:0];
               rp_in = req_tdata[31:16];
               // restart clears all state, the step then runs from zero
               if (req_tuser[0]) begin
                  prev_l_in  = '0;
                  prev_r_in  = '0;
                  pose_x_in  = '0;
                  pose_y_in  = '0;
                  heading_in = '0;
               end
            end
         end
         OP_WHEEL: begin
            prev_l_in  = out_l;
            prev_r_in  = out_r;
            sum_in     = SUM_W'(out_l) + SUM_W'(out_r);
            heading_in = h_wrap[HDG_W-1:0];
            // CORDIC runs on the heading held before this step
            x_in       = CORDIC_K;
            y_in       = '0;
            iter_in    = '0;
            if (h_old > HALF_PI_A) begin
               z_in   = h_old - PI_A;
               neg_in = 1'b1;
            end else if (h_old < -HALF_PI_A) begin
               z_in   = h_old + PI_A;
               neg_in = 1'b1;
            end else begin
               z_in   = h_old;
               neg_in = 1'b0;
            end
         end
         OP_ITER: begin
            iter_in = iter_ff + ITER_W'(1);
            if (!z_ff[ANG_W-1]) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - ANG_W'(atan_val);
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + ANG_W'(atan_val);
            end
         end
         OP_MULX, OP_MULY: begin
            prod_in = PROD_W'(sum_ff) * PROD_W'(mul_op);
         end
         OP_ADDX: begin
            pose_x_in = sat_add(pose_x_ff, prod_ff);
         end
         OP_ADDY: begin
            pose_y_in = sat_add(pose_y_ff, prod_ff);
         end
         OP_DONE: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_x_in       = pose_x_ff;
               rsp_y_in       = pose_y_ff;
               rsp_heading_in = heading_ff;
            end
         end
         default: begin
         end
      endcase

      // conditional jumps
      case (ctrl.cond)
         C_NEXT: begin
         end
         C_REQ_IDLE: begin
            if (!req_accept) begin
               pc_in = ctrl.target;
            end
         end
         C_ITER_MORE: begin
            if (iter_ff != ITER_LAST) begin
               pc_in = ctrl.target;
            end
         end
         C_RSP_BUSY: begin
            if (!rsp_free) begin
               pc_in = ctrl.target;
            end
         end
         default: begin
         end
      endcase
   end

   // control and model state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_WAIT;
         rsp_valid_ff <= 1'b0;
         prev_l_ff    <= '0;
         prev_r_ff    <= '0;
         pose_x_ff    <= '0;
         pose_y_ff    <= '0;
         heading_ff   <= '0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_l_ff    <= prev_l_in;
         prev_r_ff    <= prev_r_in;
         pose_x_ff    <= pose_x_in;
         pose_y_ff    <= pose_y_in;
         heading_ff   <= heading_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      lp_ff          <= lp_in;
      rp_ff          <= rp_in;
      sum_ff         <= sum_in;
      x_ff           <= x_in;
      y_ff           <= y_in;
      z_ff           <= z_in;
      neg_ff         <= neg_in;
      iter_ff        <= iter_in;
      prod_ff        <= prod_in;
      rsp_x_ff       <= rsp_x_in;
      rsp_y_ff       <= rsp_y_in;
      rsp_heading_ff <= rsp_heading_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_heading_ff, rsp_y_ff, rsp_x_ff};

   // checks
   `DDO_ASSERT_NOW(a_heading_range, clock, reset, rsp_valid_ff, (rsp_heading_ff <= PI_H) && (rsp_heading_ff >= -PI_H))
   `DDO_ASSERT_NOW(a_iter_bound, clock, reset, ctrl.op == OP_ITER, iter_ff <= ITER_LAST)
   `DDO_ASSERT_NEXT(a_accept_starts, clock, reset, req_accept, ctrl.op == OP_WHEEL)
   `DDO_ASSERT_NEXT(a_rsp_loaded, clock, reset, (ctrl.op == OP_DONE) && rsp_free, rsp_valid_ff && (pc_ff == STEP_WAIT))

endmodule

`default_nettype wire
